// ----- hw/rtl/szc_pkg.sv -----
// Shared widths, codes, types and helper functions of the shower depth correction core.
package szc_pkg;

  localparam int FRAC_BITS = 12;

  localparam int E_W   = 20;
  localparam int POS_W = 17;
  localparam int ZR_W  = 18;
  localparam int C_W   = 16;
  localparam int CFG_W = 18;
  localparam int IDX_W = 3;

  localparam int LOG_W = FRAC_BITS + 5;
  localparam int L2_W  = FRAC_BITS + 7;
  localparam int S_W   = FRAC_BITS + 8;
  localparam int LP_W  = L2_W + 34;
  localparam int SX_W  = S_W + 17;
  localparam int P_W   = SX_W + 16;
  localparam int D_W   = S_W - FRAC_BITS + 16;
  localparam int SUM_W = 37;
  localparam int H_W   = 19;
  localparam int RW    = SUM_W + 1;
  localparam int Q_W   = D_W - 1;
  localparam int MAG_W = Q_W + ZR_W;
  localparam int NUM_W = MAG_W + 1;
  localparam int Z_W   = Q_W + 2;

  localparam int EIGHT_F = 8 << FRAC_BITS;
  localparam int Q_UP    = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
  localparam int Q_DN    = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;
  localparam int Q_RND   = (1 << Q_DN) >> 1;

  // ln(2) in Q0.32
  localparam logic signed [33:0] LN2_S = 34'sd2977044472;

  localparam logic [ZR_W-1:0] Z_MAX = '1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [IDX_W-1:0] REG_EC     = 3'd0;
  localparam logic [IDX_W-1:0] REG_X0     = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZREF   = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOGC   = 3'd3;
  localparam logic [IDX_W-1:0] REG_COFF   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CSCALE = 3'd5;

  typedef struct packed {
    logic [C_W-1:0]         ec;
    logic [C_W-1:0]         x0;
    logic [ZR_W-1:0]        zref;
    logic signed [C_W-1:0]  logc;
    logic signed [C_W-1:0]  coff;
    logic signed [C_W-1:0]  cscale;
  } szc_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    zero;
  } szc_side_t;

  function automatic logic [4:0] msb_pos(input logic [31:0] val);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (val[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Q4.12 to FRAC_BITS fraction bits, half up when bits are dropped
  function automatic logic signed [S_W-1:0] q12_to_f(input logic signed [C_W-1:0] val);
    logic signed [S_W:0] t;
    t = (S_W + 1)'(val);
    if (FRAC_BITS >= 12) t = t <<< Q_UP;
    else t = (t + (S_W + 1)'(Q_RND)) >>> Q_DN;
    return t[S_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/szc_log_pipe.sv -----
// Two-lane log2 pipeline: normalize, then one squaring step per stage for E and Ec.
module szc_log_pipe
  import szc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [E_W-1:0]          energy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [C_W-1:0]          ec,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LOG_W-1:0]        lg_e,
  output logic [LOG_W-1:0]        lg_c,
  output szc_side_t               side_out
);

  localparam int NS = FRAC_BITS + 1;

  logic             v  [NS];
  logic [NS:0]      en;
  logic [31:0]      me [NS];
  logic [31:0]      mc [NS];
  logic [LOG_W-1:0] le [NS];
  logic [LOG_W-1:0] lc [NS];
  szc_side_t        sd [NS];

  logic [31:0] ve, vc;
  logic [4:0]  pe, pc;

  assign en[NS] = ~out_stall;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign in_stall = ~en[0];

  // zero energy is flagged; zero Ec counts as one
  assign ve = (energy == '0) ? 32'd1 : 32'(energy);
  assign vc = (ec == '0) ? 32'd1 : 32'(ec);
  assign pe = msb_pos(ve);
  assign pc = msb_pos(vc);

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en[0]) v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      me[0]      <= ve << (5'd31 - pe);
      mc[0]      <= vc << (5'd31 - pc);
      le[0]      <= LOG_W'(pe) << FRAC_BITS;
      lc[0]      <= LOG_W'(pc) << FRAC_BITS;
      sd[0].x    <= pos_x;
      sd[0].y    <= pos_y;
      sd[0].zero <= (energy == '0);
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_sq
    logic [63:0] pre, prc;
    assign pre = 64'(me[k-1]) * 64'(me[k-1]);
    assign prc = 64'(mc[k-1]) * 64'(mc[k-1]);

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en[k]) v[k] <= v[k-1];
    end

    // square is in [1,4): top bit set means the next fraction bit is one
    always_ff @(posedge clk) begin
      if (en[k]) begin
        me[k] <= pre[63] ? pre[63:32] : pre[62:31];
        mc[k] <= prc[63] ? prc[63:32] : prc[62:31];
        le[k] <= le[k-1] | (LOG_W'(pre[63]) << (FRAC_BITS - k));
        lc[k] <= lc[k-1] | (LOG_W'(prc[63]) << (FRAC_BITS - k));
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign lg_e      = le[NS-1];
  assign lg_c      = lc[NS-1];
  assign side_out  = sd[NS-1];

endmodule

// ----- hw/rtl/szc_scale_pipe.sv -----
// Depth term pipeline: ln(E/Ec), offsets, X0 and scale products; sum of squares alongside.
module szc_scale_pipe
  import szc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  szc_cfg_t              cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LOG_W-1:0]      lg_e,
  input  logic [LOG_W-1:0]      lg_c,
  input  szc_side_t             side_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [D_W-1:0] d,
  output logic [SUM_W-1:0]      sum,
  output logic                  zero
);

  localparam int NS = 6;

  logic        v  [NS];
  logic        zr [NS];
  logic [NS:0] en;

  logic signed [L2_W-1:0]    l2n, l2_0;
  logic signed [2*POS_W-1:0] xsq, ysq;
  logic [2*ZR_W-1:0]         zsq;
  logic [32:0]               xx0, yy0;
  logic [2*ZR_W-1:0]         zz0;
  logic signed [LP_W-1:0]    lp1, lp_half, lnv;
  logic signed [S_W-1:0]     s2;
  logic signed [SX_W-1:0]    sx3;
  logic signed [P_W-1:0]     p4, p_half;
  logic signed [D_W-1:0]     d5;
  logic [SUM_W-1:0]          sum1, sum2, sum3, sum4, sum5;

  assign en[NS] = ~out_stall;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign in_stall = ~en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) v[k] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) zr[0] <= side_in.zero;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) zr[k] <= zr[k-1];
    end
  end

  // log2(E) + 8 - log2(Ec): Ec carries 8 fraction bits
  assign l2n     = L2_W'(lg_e) + L2_W'(EIGHT_F) - L2_W'(lg_c);
  assign xsq     = side_in.x * side_in.x;
  assign ysq     = side_in.y * side_in.y;
  assign zsq     = cfg.zref * cfg.zref;
  assign lp_half = LP_W'(33'h0_8000_0000);
  assign lnv     = (lp1 + lp_half) >>> 32;
  assign p_half  = P_W'(1) <<< (FRAC_BITS + 15);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l2_0 <= l2n;
      xx0  <= xsq[32:0];
      yy0  <= ysq[32:0];
      zz0  <= zsq;
    end
    if (en[1]) begin
      lp1  <= l2_0 * LN2_S;
      sum1 <= SUM_W'(zz0) + SUM_W'(xx0) + SUM_W'(yy0);
    end
    if (en[2]) begin
      s2   <= S_W'(lnv) + q12_to_f(cfg.logc) + q12_to_f(cfg.coff);
      sum2 <= sum1;
    end
    if (en[3]) begin
      sx3  <= s2 * $signed({1'b0, cfg.x0});
      sum3 <= sum2;
    end
    if (en[4]) begin
      p4   <= sx3 * cfg.cscale;
      sum4 <= sum3;
    end
    if (en[5]) begin
      d5   <= D_W'((p4 + p_half) >>> (FRAC_BITS + 16));
      sum5 <= sum4;
    end
  end

  assign out_valid = v[NS-1];
  assign d         = d5;
  assign sum       = sum5;
  assign zero      = zr[NS-1];

endmodule

// ----- hw/rtl/szc_root_pipe.sv -----
// Integer square root pipeline, one result bit per stage.
module szc_root_pipe
  import szc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SUM_W-1:0]      sum,
  input  logic signed [D_W-1:0] d_in,
  input  logic                  zero_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [H_W-1:0]        h,
  output logic signed [D_W-1:0] d_out,
  output logic                  zero_out
);

  localparam int NS = H_W;

  logic                  v  [NS];
  logic [RW-1:0]         rr [NS];
  logic [SUM_W-1:0]      rm [NS];
  logic signed [D_W-1:0] dd [NS];
  logic                  zz [NS];
  logic [NS:0]           en;

  assign en[NS] = ~out_stall;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign in_stall = ~en[0];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (H_W - 1 - k));
    logic [RW-1:0]         rp, t;
    logic [SUM_W-1:0]      mp;
    logic signed [D_W-1:0] dp;
    logic                  zp, vp, ge;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign mp = sum;
      assign dp = d_in;
      assign zp = zero_in;
      assign vp = in_valid;
    end else begin : g_next
      assign rp = rr[k-1];
      assign mp = rm[k-1];
      assign dp = dd[k-1];
      assign zp = zz[k-1];
      assign vp = v[k-1];
    end

    assign t  = rp + BIT;
    assign ge = (RW'(mp) >= t);

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (en[k]) v[k] <= vp;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (ge) begin
          rm[k] <= mp - t[SUM_W-1:0];
          rr[k] <= (rp >> 1) + BIT;
        end else begin
          rm[k] <= mp;
          rr[k] <= rp >> 1;
        end
        dd[k] <= dp;
        zz[k] <= zp;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign h         = rr[NS-1][H_W-1:0];
  assign d_out     = dd[NS-1];
  assign zero_out  = zz[NS-1];

endmodule

// ----- hw/rtl/szc_div_pipe.sv -----
// Cosine correction: |d|*Zref/h by restoring division, sign, Zref offset and saturation.
module szc_div_pipe
  import szc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ZR_W-1:0]       zref,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [H_W-1:0]        h,
  input  logic signed [D_W-1:0] d,
  input  logic                  zero,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ZR_W-1:0]       z_corrected,
  output logic [1:0]            status
);

  // stage 0 product, stage 1 rounded numerator, stages 2..Q_W+1 division, last stage result
  localparam int NS = Q_W + 3;
  localparam int ND = Q_W + 1;

  logic        v [NS];
  logic [NS:0] en;

  logic [D_W-1:0]   ad;
  logic [MAG_W-1:0] mag0;
  logic [H_W-1:0]   h0;
  logic             ng0, zf0;

  logic [NUM_W-1:0] rm [ND];
  logic [Q_W-1:0]   qq [ND];
  logic [H_W-1:0]   hh [ND];
  logic             ng [ND];
  logic             zf [ND];

  logic signed [Z_W-1:0] corr, zs;
  logic [ZR_W-1:0]       z_res;
  logic [1:0]            st_res;

  assign en[NS] = ~out_stall;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign in_stall = ~en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) v[k] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign ad = d[D_W-1] ? D_W'(-d) : D_W'(d);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag0 <= ad[Q_W-1:0] * zref;
      h0   <= h;
      ng0  <= d[D_W-1];
      zf0  <= zero;
    end
    // numerator with half the divisor added, for round to nearest
    if (en[1]) begin
      rm[0] <= NUM_W'(mag0) + NUM_W'(h0 >> 1);
      qq[0] <= '0;
      hh[0] <= h0;
      ng[0] <= ng0;
      zf[0] <= zf0;
    end
  end

  for (genvar j = 1; j < ND; j++) begin : g_div
    localparam int QB = Q_W - j;
    logic [NUM_W:0] hs;
    logic           ge;

    assign hs = (NUM_W + 1)'(hh[j-1]) << QB;
    assign ge = ((NUM_W + 1)'(rm[j-1]) >= hs);

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        rm[j] <= ge ? rm[j-1] - hs[NUM_W-1:0] : rm[j-1];
        qq[j] <= qq[j-1] | (ge ? (Q_W'(1) << QB) : '0);
        hh[j] <= hh[j-1];
        ng[j] <= ng[j-1];
        zf[j] <= zf[j-1];
      end
    end
  end

  // zero Zref means a zero cosine; h is zero only then
  assign corr = (zref == '0) ? '0 :
                ng[ND-1] ? -Z_W'(qq[ND-1]) : Z_W'(qq[ND-1]);
  assign zs   = Z_W'(zref) + corr;

  always_comb begin
    if (zf[ND-1]) begin
      z_res  = '0;
      st_res = ST_ZERO;
    end else if (zs < 0) begin
      z_res  = '0;
      st_res = ST_SAT;
    end else if (zs > Z_W'(Z_MAX)) begin
      z_res  = Z_MAX;
      st_res = ST_SAT;
    end else begin
      z_res  = zs[ZR_W-1:0];
      st_res = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      z_corrected <= z_res;
      status      <= st_res;
    end
  end

  assign out_valid = v[NS-1];

endmodule

// ----- hw/rtl/shower_depth_z_correction_core.sv -----
// Shower depth correction core: configuration registers and the four-part pipeline.
//
// One cluster (energy in MeV, x and y in 1/16 mm) enters per clock and one
// corrected depth leaves per clock while result_stall is low. The log2 squaring
// steps, the nineteen square root steps and the one-bit-per-stage quotient set
// the depth. Each stage holds its own valid bit and stall ripples back only
// through full stages, so bubbles close up while a result waits. Status is 0
// for a normal result, 1 for zero energy (z = 0) and 2 when z was clamped to 0
// or 262143. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the pipeline is empty, as the block itself
// does not enforce this.
module shower_depth_z_correction_core
  import szc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [E_W-1:0]          energy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [ZR_W-1:0]         z_corrected,
  output logic [1:0]              status
);

  szc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ec     <= 16'd1869;
      cfg.x0     <= 16'd4378;
      cfg.zref   <= 18'd199840;
      cfg.logc   <= -16'sd3277;
      cfg.coff   <= 16'sd0;
      cfg.cscale <= 16'sd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EC:     cfg.ec     <= cfg_data[C_W-1:0];
        REG_X0:     cfg.x0     <= cfg_data[C_W-1:0];
        REG_ZREF:   cfg.zref   <= cfg_data[ZR_W-1:0];
        REG_LOGC:   cfg.logc   <= cfg_data[C_W-1:0];
        REG_COFF:   cfg.coff   <= cfg_data[C_W-1:0];
        REG_CSCALE: cfg.cscale <= cfg_data[C_W-1:0];
        default: ;
      endcase
    end
  end

  logic             lg_valid, lg_stall;
  logic [LOG_W-1:0] lg_e, lg_c;
  szc_side_t        lg_side;

  logic                  sc_valid, sc_stall, sc_zero;
  logic signed [D_W-1:0] sc_d;
  logic [SUM_W-1:0]      sc_sum;

  logic                  rt_valid, rt_stall, rt_zero;
  logic [H_W-1:0]        rt_h;
  logic signed [D_W-1:0] rt_d;

  szc_log_pipe u_log (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_stall  (item_stall),
    .energy    (energy),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .ec        (cfg.ec),
    .out_valid (lg_valid),
    .out_stall (lg_stall),
    .lg_e      (lg_e),
    .lg_c      (lg_c),
    .side_out  (lg_side)
  );

  szc_scale_pipe u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (lg_valid),
    .in_stall  (lg_stall),
    .lg_e      (lg_e),
    .lg_c      (lg_c),
    .side_in   (lg_side),
    .out_valid (sc_valid),
    .out_stall (sc_stall),
    .d         (sc_d),
    .sum       (sc_sum),
    .zero      (sc_zero)
  );

  szc_root_pipe u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_stall  (sc_stall),
    .sum       (sc_sum),
    .d_in      (sc_d),
    .zero_in   (sc_zero),
    .out_valid (rt_valid),
    .out_stall (rt_stall),
    .h         (rt_h),
    .d_out     (rt_d),
    .zero_out  (rt_zero)
  );

  szc_div_pipe u_div (
    .clk         (clk),
    .rst         (rst),
    .zref        (cfg.zref),
    .in_valid    (rt_valid),
    .in_stall    (rt_stall),
    .h           (rt_h),
    .d           (rt_d),
    .zero        (rt_zero),
    .out_valid   (result_valid),
    .out_stall   (result_stall),
    .z_corrected (z_corrected),
    .status      (status)
  );

  // input backs up only when a result is waiting downstream
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled with no waiting result");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_ZERO) |-> (z_corrected == '0))
    else $error("zero energy result with nonzero depth");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_SAT))
    else $error("undefined status code");

  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule
